/* rtl/maf_pkg.sv */
// package for the moving average filter: shared constants, register map and state types
// no dependencies; imported by every rtl module of the filter
`timescale 1ns / 1ps

package maf_pkg;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // configuration register map, index = byte address / 4
    localparam int  CFG_W      = 6;
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(16);

    typedef enum logic {
        FS_IDLE,
        FS_CALC
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_DONE
    } t_back_state;

endpackage

/* rtl/maf_fifo.sv */
// two-entry job queue between the front (sum update) and the back (divider)
// depends on maf_pkg only through the common import convention
`timescale 1ns / 1ps

module maf_fifo
    import maf_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("job queue count out of range");
`endif

endmodule

/* rtl/maf_front.sv */
// front end: takes samples, keeps the history ring, fill count and running sum,
// and queues one (sum, divisor) job per sample; uses maf_pkg
`timescale 1ns / 1ps

module maf_front
    import maf_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW),
    parameter int CNT_W       = $clog2(MAX_WINDOW + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    input  logic                    i_record_start,
    input  logic [CNT_W-1:0]        i_len,
    input  logic                    i_clear,
    output logic                    o_job_push,
    input  logic                    i_job_full,
    output logic signed [SUM_W-1:0] o_job_sum,
    output logic [CNT_W-1:0]        o_job_div
);

    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int IDX_W  = SLOT_W + 2;

    t_front_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_hist [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_old;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_slide;
    logic                   r_restart;
    logic [CNT_W-1:0]       r_div;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]       r_fill;
    logic [SLOT_W-1:0]      r_slot;

    logic                   accept;
    logic [CNT_W-1:0]       fill_eff;
    logic [SLOT_W-1:0]      slot_eff;
    logic [IDX_W-1:0]       old_raw;
    logic [SLOT_W-1:0]      old_slot;
    logic                   slide;
    logic signed [SUM_W-1:0] sum_base;

    assign accept   = i_push && !o_full;
    assign fill_eff = i_record_start ? '0 : r_fill;
    assign slot_eff = i_record_start ? '0 : r_slot;
    assign slide    = (fill_eff >= i_len);

    // slot of the sample that drops out of the window
    always_comb begin
        old_raw = IDX_W'(slot_eff) + IDX_W'(MAX_WINDOW) - IDX_W'(i_len);
        if (old_raw >= IDX_W'(MAX_WINDOW)) begin
            old_raw = old_raw - IDX_W'(MAX_WINDOW);
        end
        old_slot = old_raw[SLOT_W-1:0];
    end

    always_comb begin
        sum_base  = r_restart ? '0 : r_sum;
        o_job_sum = sum_base + SUM_W'($signed(r_sample))
                    - (r_slide ? SUM_W'($signed(r_old)) : '0);
        o_job_div = r_div;
    end

    always_comb begin
        n_state    = r_state;
        o_full     = 1'b1;
        o_job_push = 1'b0;
        unique case (r_state)
            FS_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_state = FS_CALC;
                end
            end
            FS_CALC: begin
                o_job_push = 1'b1;
                if (!i_job_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum  <= '0;
            r_fill <= '0;
            r_slot <= '0;
        end else if (accept) begin
            r_fill <= slide ? fill_eff : fill_eff + CNT_W'(1);
            r_slot <= (slot_eff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_eff + SLOT_W'(1);
        end else if (o_job_push && !i_job_full) begin
            r_sum <= o_job_sum;
        end
    end

    // history ring, read-first so a full-depth window sees the old entry
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hist[slot_eff] <= i_sample;
            r_old            <= r_hist[old_slot];
            r_sample         <= i_sample;
            r_slide          <= slide;
            r_restart        <= i_record_start;
            r_div            <= slide ? i_len : fill_eff + CNT_W'(1);
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= i_len)
        else $error("fill count beyond window length");
    a_job_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> (o_job_div != '0) && (o_job_div <= i_len))
        else $error("job divisor out of range");
`endif

endmodule

/* rtl/maf_back.sv */
// back end: restoring bit-serial divider, one quotient bit per cycle, plus the
// result register seen on the output queue ports; uses maf_pkg
`timescale 1ns / 1ps

module maf_back
    import maf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SUM_W       = SAMPLE_BITS + 5,
    parameter int CNT_W       = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_job_empty,
    output logic                    o_job_pop,
    input  logic signed [SUM_W-1:0] i_job_sum,
    input  logic [CNT_W-1:0]        i_job_div,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic [SAMPLE_BITS-1:0]  o_average
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic signed [SUM_W:0] SAT_HI =
        (SUM_W+1)'(({{SUM_W{1'b0}}, 1'b1} << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W:0] SAT_LO = ~SAT_HI;

    t_back_state r_state, n_state;

    logic [SUM_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_div;
    logic                   r_neg;
    logic [STEP_W-1:0]      r_step;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_avg;

    logic [CNT_W:0]          rem_sh;
    logic                    ge;
    logic signed [SUM_W:0]   quo_signed;
    logic [SAMPLE_BITS-1:0]  avg_sat;
    logic                    load;
    logic                    finish;

    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_div});

    always_comb begin
        quo_signed = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        if (quo_signed > SAT_HI) begin
            avg_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (quo_signed < SAT_LO) begin
            avg_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            avg_sat = quo_signed[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        load      = 1'b0;
        finish    = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_job_empty) begin
                    load    = 1'b1;
                    n_state = BS_DIV;
                end
            end
            BS_DIV: begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                // result waits here while the output register is still occupied
                if (!r_out_valid || i_pop) begin
                    finish  = 1'b1;
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    assign o_job_pop = load;
    assign o_empty   = !r_out_valid;
    assign o_average = r_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_neg  <= i_job_sum[SUM_W-1];
            r_quo  <= i_job_sum[SUM_W-1] ? (~i_job_sum + SUM_W'(1)) : i_job_sum;
            r_rem  <= '0;
            r_div  <= i_job_div;
            r_step <= '0;
        end else if (r_state == BS_DIV) begin
            r_rem  <= ge ? CNT_W'(rem_sh - {1'b0, r_div}) : rem_sh[CNT_W-1:0];
            r_quo  <= {r_quo[SUM_W-2:0], ge};
            r_step <= r_step + STEP_W'(1);
        end
        if (finish) begin
            r_avg <= avg_sat;
        end
    end

`ifndef SYNTH
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DIV) |-> (r_div != '0))
        else $error("divide by zero in serial divider");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_avg)))
        else $error("pending result lost before pop");
`endif

endmodule

/* rtl/moving_average_filter_unit.sv */
// moving average filter: front end, job queue and serial divider back end,
// window register on the apb-style port; uses maf_pkg, maf_front, maf_fifo, maf_back
// the serial divider, sized by SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW), limits the transaction rate
// front end can take new samples while the divider works on the previous one, until the job queue fills
// reset: synchronous active low; clears sum, fill count, queues, window length back to 16
`timescale 1ns / 1ps

module moving_average_filter_unit
    import maf_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_record_start,
    output logic                   empty,
    input  logic                   pop,
    output logic [SAMPLE_BITS-1:0] o_average,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int JOB_W = SUM_W + CNT_W;

    logic [CFG_W-1:0] r_window_length;
    logic [CNT_W-1:0] len;
    logic             cfg_wr;

    logic                    job_push;
    logic                    job_full;
    logic signed [SUM_W-1:0] front_sum;
    logic [CNT_W-1:0]        front_div;
    logic [JOB_W-1:0]        q_out;
    logic                    job_empty;
    logic                    job_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == REG_WINDOW_LENGTH);
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? 32'(r_window_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_RESET;
        end else if (cfg_wr) begin
            r_window_length <= pwdata[CFG_W-1:0];
        end
    end

    // zero acts as a window of one, large values clip to the ring depth
    always_comb begin
        if (r_window_length == '0) begin
            len = CNT_W'(1);
        end else if (32'(r_window_length) > MAX_WINDOW) begin
            len = CNT_W'(MAX_WINDOW);
        end else begin
            len = CNT_W'(r_window_length);
        end
    end

    maf_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_sample       (i_sample),
        .i_record_start (i_record_start),
        .i_len          (len),
        .i_clear        (cfg_wr),
        .o_job_push     (job_push),
        .i_job_full     (job_full),
        .o_job_sum      (front_sum),
        .o_job_div      (front_div)
    );

    maf_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  ({front_sum, front_div}),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (q_out),
        .o_empty (job_empty)
    );

    maf_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_job_sum   ($signed(q_out[JOB_W-1:CNT_W])),
        .i_job_div   (q_out[CNT_W-1:0]),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_average   (o_average)
    );

endmodule

/* sim/tb_moving_average_filter_unit.sv */
// testbench for moving_average_filter_unit: queue-style sample/average ports, apb window register
// depends on rtl/maf_pkg.sv and the filter rtl; an inline running-mean model predicts every average
`timescale 1ns / 1ps

module tb_moving_average_filter_unit;
    import maf_pkg::*;

    localparam int NSLOT        = MAX_WINDOW_DEF;
    localparam int SW           = SAMPLE_BITS_DEF;
    localparam int SETTLE       = 32;      // longer than the push-to-result latency
    localparam int HOLD_CYCLES  = 2000;    // long receiver hold-off for the back-pressure test
    localparam int MAX_PRINTS   = 40;
    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    logic [SW-1:0] i_sample;
    logic          i_record_start;
    logic          empty;
    logic          pop;
    logic [SW-1:0] o_average;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    moving_average_filter_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_sample       (i_sample),
        .i_record_start (i_record_start),
        .empty          (empty),
        .pop            (pop),
        .o_average      (o_average),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // filter model state
    logic [5:0]           win_reg;
    logic signed [SW-1:0] hist [NSLOT];
    int                   run_sum;
    int                   fill_cnt;
    int                   wr_slot;

    logic [SW-1:0] pending_avgs [$];

    int errors;
    int prints;
    int samples_sent;
    int averages_seen;
    int records_started;
    int window_writes;
    int full_cycles;
    int send_idle_pct;
    int stall_pct;
    int hold_req;

    logic [5:0] window_picks [8] = '{6'd0, 6'd1, 6'd2, 6'd31, 6'd32, 6'd33, 6'd63, 6'd16};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void clear_record();
        run_sum  = 0;
        fill_cnt = 0;
        wr_slot  = 0;
    endfunction

    function automatic logic [SW-1:0] advance_filter(input logic signed [SW-1:0] s,
                                                     input logic start);
        int span;
        int oldest;
        int mean;
        span = (win_reg == 0) ? 1 : ((win_reg > NSLOT) ? NSLOT : int'(win_reg));
        if (start) begin
            clear_record();
        end
        if (fill_cnt < span) begin
            run_sum  = run_sum + s;
            fill_cnt = fill_cnt + 1;
            mean     = run_sum / fill_cnt;
        end else begin
            oldest  = (wr_slot + NSLOT - span) % NSLOT;
            run_sum = run_sum - hist[oldest] + s;
            mean    = run_sum / span;
        end
        hist[wr_slot] = s;
        wr_slot = (wr_slot + 1) % NSLOT;
        if (mean > $signed(S_MAX)) begin
            mean = $signed(S_MAX);
        end
        if (mean < $signed(S_MIN)) begin
            mean = $signed(S_MIN);
        end
        return SW'(mean);
    endfunction

    // result side: checks each popped average and drives pop, with an optional long hold-off
    initial begin : result_side
        int hold_left;
        int hold_seen;
        logic [SW-1:0] want;
        hold_left = 0;
        hold_seen = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                averages_seen++;
                if (pending_avgs.size() == 0) begin
                    errors++;
                    if (prints < MAX_PRINTS) begin
                        prints++;
                        $display("%0t: unexpected average: expected none, actual %0d",
                                 $time, $signed(o_average));
                    end
                end else begin
                    want = pending_avgs.pop_front();
                    if (o_average !== want) begin
                        errors++;
                        if (prints < MAX_PRINTS) begin
                            prints++;
                            $display("%0t: average mismatch: expected %0d, actual %0d",
                                     $time, $signed(want), $signed(o_average));
                        end
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // one sample transaction; returns right after the accepting edge or an idle stretch
    task automatic send_sample(input logic [SW-1:0] s, input logic start);
        push           <= 1'b1;
        i_sample       <= s;
        i_record_start <= start;
        @(posedge i_clk);
        while (full) begin
            full_cycles++;
            @(posedge i_clk);
        end
        pending_avgs.push_back(advance_filter(s, start));
        samples_sent++;
        if (start) begin
            records_started++;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        push <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_avgs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write; upper data bits are random and must be ignored
    task automatic write_window(input logic [5:0] w);
        logic [31:0] d;
        d      = $urandom();
        d[5:0] = w;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_LENGTH, 2'b00};
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        win_reg = w;
        clear_record();
        window_writes++;
    endtask

    function automatic logic [SW-1:0] random_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SW'($urandom_range(0, 31) - 16);
            default: return SW'($urandom());
        endcase
    endfunction

    function automatic int record_length();
        case ($urandom_range(9))
            0:       return $urandom_range(1, 3);
            1, 2:    return $urandom_range(4, 40);
            default: return $urandom_range(40, 130);
        endcase
    endfunction

    task automatic test_reset_window();
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b0);
        stop_sending();
        wait_idle();
    endtask

    // zero window acts as one, oversized window saturates, record start mid-stream
    task automatic test_window_edges();
        write_window(6'd0);
        send_sample(S_MIN, 1'b1);
        send_sample(16'hFFFD, 1'b0);
        send_sample(S_MAX, 1'b0);
        stop_sending();
        wait_idle();
        write_window(6'd63);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        stop_sending();
        wait_idle();
        write_window(6'd2);
        send_sample(16'd5, 1'b0);
        send_sample(16'hFFF9, 1'b0);
        send_sample(16'd100, 1'b1);
        send_sample(16'd3, 1'b0);
        stop_sending();
        wait_idle();
    endtask

    // a window write clears the sum even when the value does not change
    task automatic test_window_rewrite();
        write_window(6'd3);
        send_sample(16'd10, 1'b0);
        send_sample(16'd20, 1'b0);
        stop_sending();
        wait_idle();
        write_window(6'd3);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFE, 1'b0);
        stop_sending();
        wait_idle();
    endtask

    // receiver holds off while samples keep coming, so the block fills and raises full
    task automatic test_backpressure();
        stall_pct     <= 0;
        send_idle_pct = 0;
        write_window(6'd8);
        hold_req <= hold_req + 1;
        for (int n = 0; n < 120; n++) begin
            send_sample(random_sample(), (n % 40) == 0);
        end
        stop_sending();
        wait_idle();
    endtask

    task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
        int   done;
        int   chunk;
        int   rec_left;
        logic start;
        stall_pct     <= recv_pct;
        send_idle_pct = send_pct;
        done = 0;
        while (done < n_items) begin
            wait_idle();
            if (window_writes % 10 < 8) begin
                write_window(window_picks[window_writes % 10]);
            end else begin
                write_window(6'($urandom_range(0, 63)));
            end
            chunk    = $urandom_range(60, 140);
            if (chunk > n_items - done) begin
                chunk = n_items - done;
            end
            rec_left = 0;
            repeat (chunk) begin
                start = ($urandom_range(49) == 0);
                if (rec_left == 0) begin
                    rec_left = record_length();
                    start    = 1'b1;
                end
                send_sample(random_sample(), start);
                rec_left--;
                done++;
            end
            stop_sending();
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_sample       <= '0;
        i_record_start <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        errors          = 0;
        prints          = 0;
        samples_sent    = 0;
        averages_seen   = 0;
        records_started = 0;
        window_writes   = 0;
        full_cycles     = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_req        = 0;
        win_reg         = WINDOW_RESET;
        for (int k = 0; k < NSLOT; k++) begin
            hist[k] = '0;
        end
        clear_record();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_window();
        test_window_edges();
        test_window_rewrite();
        test_backpressure();
        test_random(400, 0, 0);
        test_random(400, 59, 0);
        test_random(400, 0, 59);
        test_random(400, 26, 26);

        $display("tb: %0d samples, %0d averages checked, %0d records, %0d window writes",
                 samples_sent, averages_seen, records_started, window_writes);
        $display("tb: %0d cycles with the input held off by full, %0d errors",
                 full_cycles, errors);
        if (errors == 0 && pending_avgs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/maf_pkg.sv
rtl/maf_fifo.sv
rtl/maf_front.sv
rtl/maf_back.sv
rtl/moving_average_filter_unit.sv
sim/tb_moving_average_filter_unit.sv
